// File: rtl/core/lrupr_pkg.sv
`timescale 1ns / 1ps

package lrupr_pkg;

  localparam int STAMP_W     = 32;
  localparam int FAULT_W     = 16;
  localparam int CFG_W       = 5;
  localparam int PAGE_IN_W   = 16;
  localparam int SLOT_OUT_W  = 4;
  localparam int OUT_TDATA_W = 24;

  localparam logic [FAULT_W-1:0] FAULT_MAX   = {FAULT_W{1'b1}};
  localparam logic [CFG_W-1:0]   FRAME_COUNT_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_COMMIT
  } state_t;

  // Control for the shared compare unit.
  typedef struct packed {
    logic clear;
    logic step;
    logic row_valid;
  } scan_ctl_t;

endpackage

// File: rtl/core/lrupr_frame_mem.sv
`timescale 1ns / 1ps

module lrupr_frame_mem #(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4,
  parameter int KEY_W = 16
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [IDX_W-1:0]             rd_addr,
  output logic [KEY_W-1:0]             rd_page,
  output logic [lrupr_pkg::STAMP_W-1:0] rd_stamp,
  input  logic                         wr_page_en,
  input  logic                         wr_stamp_en,
  input  logic [IDX_W-1:0]             wr_addr,
  input  logic [KEY_W-1:0]             wr_page,
  input  logic [lrupr_pkg::STAMP_W-1:0] wr_stamp
);
  import lrupr_pkg::*;

  logic [KEY_W-1:0]   page_mem  [DEPTH];
  logic [STAMP_W-1:0] stamp_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_page_en) begin
      page_mem[wr_addr] <= wr_page;
    end
    if (wr_stamp_en) begin
      stamp_mem[wr_addr] <= wr_stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_page  <= page_mem[rd_addr];
      rd_stamp <= stamp_mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/lrupr_scan_unit.sv
`timescale 1ns / 1ps

module lrupr_scan_unit #(
  parameter int IDX_W = 4,
  parameter int KEY_W = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lrupr_pkg::scan_ctl_t          ctl,
  input  logic [IDX_W-1:0]              idx,
  input  logic [KEY_W-1:0]              key,
  input  logic [KEY_W-1:0]              row_page,
  input  logic [lrupr_pkg::STAMP_W-1:0] row_stamp,
  output logic                          hit,
  output logic [IDX_W-1:0]              slot
);
  import lrupr_pkg::*;

  logic               found;
  logic               empty_seen;
  logic               have_min;
  logic [IDX_W-1:0]   hit_idx;
  logic [IDX_W-1:0]   empty_idx;
  logic [IDX_W-1:0]   min_idx;
  logic [STAMP_W-1:0] min_stamp;
  logic               is_match;
  logic               is_older;

  assign is_match = ctl.row_valid && (row_page == key);
  // Strict compare keeps the lowest index on equal stamps.
  assign is_older = !have_min || (row_stamp < min_stamp);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      found      <= 1'b0;
      empty_seen <= 1'b0;
      have_min   <= 1'b0;
    end else if (ctl.step) begin
      if (!found && is_match) begin
        found <= 1'b1;
      end
      if (!empty_seen && !ctl.row_valid) begin
        empty_seen <= 1'b1;
      end
      have_min <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      if (!found && is_match) begin
        hit_idx <= idx;
      end
      if (!empty_seen && !ctl.row_valid) begin
        empty_idx <= idx;
      end
      if (is_older) begin
        min_idx   <= idx;
        min_stamp <= row_stamp;
      end
    end
  end

  always_comb begin
    hit = found;
    if (found) begin
      slot = hit_idx;
    end else if (empty_seen) begin
      slot = empty_idx;
    end else begin
      slot = min_idx;
    end
  end

endmodule

// File: rtl/core/lru_page_replacement_unit.sv
`timescale 1ns / 1ps

// LRU page replacement with per-frame use stamps.
// Input stream: s_tdata carries one page reference, s_tlast marks the final
// reference of a run. Output stream: one result per reference, with the hit
// flag on m_tuser, frame slot and saturating fault total on m_tdata, and the
// end-of-run echo on m_tlast. The cfg channel writes the frame count; it is
// always ready and should be written only while no reference is in flight.
// A result is presented once its reference has been scanned and committed, and
// no new reference is accepted until that commit is done: one shared compare
// unit walks the frame memory one row per cycle, looking for a match, the
// first empty frame and the oldest stamp in a single pass, then a commit
// updates the frame.
// s_tready is high only between references.
// The result sits in an output register; the next reference is accepted and
// scanned while it waits, and a commit holds until that register is free.
// Reset (synchronous, active high) empties all frames, clears the stamp clock
// and fault total, and sets the frame count to 16. A reference with tlast
// high does the same to the frame state after its result is produced.
module lru_page_replacement_unit #(
  parameter int MAX_FRAMES = 16,
  parameter int PAGE_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  // cfg_data: frame_count[4:0]
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lrupr_pkg::CFG_W-1:0]       cfg_data,
  // s_tdata: page_number[15:0]
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [lrupr_pkg::PAGE_IN_W-1:0]   s_tdata,
  input  logic                              s_tlast,
  // m_tdata: frame_slot[3:0], fault_total[19:4], zero fill [23:20]
  // m_tuser: hit[0]
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [lrupr_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                              m_tuser,
  output logic                              m_tlast
);
  import lrupr_pkg::*;

  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int KEY_W = (PAGE_BITS < PAGE_IN_W) ? PAGE_BITS : PAGE_IN_W;

  state_t state;
  state_t state_next;

  logic [CFG_W-1:0]      frame_count;
  logic [IDX_W-1:0]      last_idx;
  logic [IDX_W-1:0]      cnt;
  logic [IDX_W-1:0]      rd_idx;
  logic                  rd_vld;
  logic [KEY_W-1:0]      key;
  logic                  key_last;
  logic [MAX_FRAMES-1:0] frame_valid;
  logic [STAMP_W-1:0]    stamp_clock;
  logic [FAULT_W-1:0]    fault_count;
  logic [FAULT_W-1:0]    fault_next;
  logic [STAMP_W-1:0]    stamp_next;

  logic               accept;
  logic               commit_go;
  logic               mem_rd_en;
  scan_ctl_t          scan_ctl;
  logic [KEY_W-1:0]   row_page;
  logic [STAMP_W-1:0] row_stamp;
  logic               scan_hit;
  logic [IDX_W-1:0]   scan_slot;
  logic [31:0]        slot_wide;

  logic               out_hit;
  logic [SLOT_OUT_W-1:0] out_slot;
  logic [FAULT_W-1:0] out_fault;
  logic               out_last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= FRAME_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      frame_count <= cfg_data;
    end
  end

  // Zero frames act as one; counts above the frame store use all of it.
  always_comb begin
    if (frame_count == '0) begin
      last_idx = '0;
    end else if (int'(frame_count) > MAX_FRAMES) begin
      last_idx = IDX_W'(MAX_FRAMES - 1);
    end else begin
      last_idx = IDX_W'(frame_count - CFG_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt == last_idx) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    mem_rd_en = 1'b0;
    commit_go = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
      end
      ST_SCAN: begin
        mem_rd_en = 1'b1;
      end
      ST_WAIT: begin
      end
      ST_COMMIT: begin
        commit_go = !m_tvalid || m_tready;
      end
      default: begin
      end
    endcase
  end

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (accept) begin
      key      <= s_tdata[KEY_W-1:0];
      key_last <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cnt <= '0;
    end else if (mem_rd_en) begin
      cnt <= cnt + IDX_W'(1);
    end
    rd_idx <= cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= mem_rd_en;
    end
  end

  assign scan_ctl.clear     = accept;
  assign scan_ctl.step      = rd_vld;
  assign scan_ctl.row_valid = frame_valid[rd_idx];

  assign fault_next = (scan_hit || fault_count == FAULT_MAX) ? fault_count
                                                             : fault_count + FAULT_W'(1);
  assign stamp_next = stamp_clock + STAMP_W'(1);

  lrupr_frame_mem #(
    .DEPTH (MAX_FRAMES),
    .IDX_W (IDX_W),
    .KEY_W (KEY_W)
  ) u_mem (
    .clk         (clk),
    .rd_en       (mem_rd_en),
    .rd_addr     (cnt),
    .rd_page     (row_page),
    .rd_stamp    (row_stamp),
    .wr_page_en  (commit_go && !scan_hit),
    .wr_stamp_en (commit_go),
    .wr_addr     (scan_slot),
    .wr_page     (key),
    .wr_stamp    (stamp_next)
  );

  lrupr_scan_unit #(
    .IDX_W (IDX_W),
    .KEY_W (KEY_W)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .ctl       (scan_ctl),
    .idx       (rd_idx),
    .key       (key),
    .row_page  (row_page),
    .row_stamp (row_stamp),
    .hit       (scan_hit),
    .slot      (scan_slot)
  );

  // Run state; the last reference of a run clears it after its commit.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= '0;
      stamp_clock <= '0;
      fault_count <= '0;
    end else if (commit_go) begin
      if (key_last) begin
        frame_valid <= '0;
        stamp_clock <= '0;
        fault_count <= '0;
      end else begin
        frame_valid[scan_slot] <= 1'b1;
        stamp_clock            <= stamp_next;
        fault_count            <= fault_next;
      end
    end
  end

  assign slot_wide = 32'(scan_slot);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit_go) begin
      out_hit   <= scan_hit;
      out_slot  <= slot_wide[SLOT_OUT_W-1:0];
      out_fault <= fault_next;
      out_last  <= key_last;
    end
  end

  assign m_tdata = {{(OUT_TDATA_W - SLOT_OUT_W - FAULT_W){1'b0}}, out_fault, out_slot};
  assign m_tuser = out_hit;
  assign m_tlast = out_last;

  // A fresh result only ever comes out of a commit.
  a_result_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_COMMIT)
    else $error("result appeared without a commit");

  // The scan never walks past the active frames.
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> cnt <= last_idx)
    else $error("scan index beyond active frames");

  // A hit leaves the fault total alone unless the run ends.
  a_hit_no_fault: assert property (@(posedge clk) disable iff (rst)
    (commit_go && scan_hit && !key_last) |=> fault_count == $past(fault_count))
    else $error("fault count changed on a hit");

  // Input is taken only between references, never while a scan is running.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> !s_tready)
    else $error("input ready during a scan");

endmodule

// File: tb/tb_lru_page_replacement_unit.sv
`timescale 1ns / 1ps

module tb_lru_page_replacement_unit;
  import lrupr_pkg::*;

  localparam int FRAMES = 16;

  typedef struct packed {
    logic                  hit;
    logic [SLOT_OUT_W-1:0] slot;
    logic [FAULT_W-1:0]    faults;
    logic                  done;
  } lru_result_t;

  typedef enum logic {ROW_REF, ROW_CFG} row_kind_t;

  // For ROW_CFG rows the page column carries the frame count to write.
  typedef struct packed {
    row_kind_t             kind;
    logic [PAGE_IN_W-1:0]  page;
    logic                  last;
    logic                  typed;
    logic                  hit;
    logic [SLOT_OUT_W-1:0] slot;
    logic [FAULT_W-1:0]    faults;
  } dir_row_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_W-1:0]       cfg_data;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [PAGE_IN_W-1:0]   s_tdata;   // page_number[15:0]
  logic                   s_tlast;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;   // frame_slot[3:0], fault_total[19:4], zero fill
  logic                   m_tuser;   // hit[0]
  logic                   m_tlast;

  lru_page_replacement_unit dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted frame table of the replacement unit.
  logic [PAGE_IN_W-1:0] frame_pages  [FRAMES];
  logic                 frame_loaded [FRAMES];
  logic [STAMP_W-1:0]   frame_stamps [FRAMES];
  logic [STAMP_W-1:0]   stamp_count;
  logic [FAULT_W-1:0]   fault_tally;
  logic [CFG_W-1:0]     frame_count_reg;

  lru_result_t pending_results[$];
  int          mismatches = 0;
  int          references_sent = 0;
  int          burst_left = 0;
  bit          fast = 1'b0;
  bit          hold_req = 1'b0;
  dir_row_t    directed_plan [27];

  function automatic void clear_frames();
    int i;
    for (i = 0; i < FRAMES; i++) begin
      frame_pages[i]  = '0;
      frame_loaded[i] = 1'b0;
      frame_stamps[i] = '0;
    end
    stamp_count = '0;
    fault_tally = '0;
  endfunction

  function automatic lru_result_t lru_reference(input logic [PAGE_IN_W-1:0] page,
                                                input logic last);
    int          n;
    int          i;
    int          slot;
    bit          found;
    bit          empty;
    lru_result_t r;
    n = int'(frame_count_reg);
    if (n < 1) n = 1;
    if (n > FRAMES) n = FRAMES;
    slot  = 0;
    found = 1'b0;
    empty = 1'b0;
    for (i = 0; i < n; i++) begin
      if (!found && frame_loaded[i] && frame_pages[i] == page) begin
        slot  = i;
        found = 1'b1;
      end
    end
    if (!found) begin
      for (i = 0; i < n; i++) begin
        if (!empty && !frame_loaded[i]) begin
          slot  = i;
          empty = 1'b1;
        end
      end
      // With every frame loaded, evict the oldest stamp, lowest index on ties.
      if (!empty) begin
        slot = 0;
        for (i = 1; i < n; i++) begin
          if (frame_stamps[i] < frame_stamps[slot]) slot = i;
        end
      end
      frame_pages[slot]  = page;
      frame_loaded[slot] = 1'b1;
      if (fault_tally != FAULT_MAX) fault_tally = fault_tally + FAULT_W'(1);
    end
    stamp_count        = stamp_count + STAMP_W'(1);
    frame_stamps[slot] = stamp_count;
    r.hit    = found;
    r.slot   = slot[SLOT_OUT_W-1:0];
    r.faults = fault_tally;
    r.done   = last;
    if (last) clear_frames();
    return r;
  endfunction

  task automatic pause_sender(input int gap);
    @(negedge clk);
    s_tvalid <= 1'b0;
    repeat (gap) @(negedge clk);
  endtask

  task automatic present_reference(input logic [PAGE_IN_W-1:0] page, input logic last,
                                   input bit typed, input lru_result_t typed_res);
    lru_result_t r;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= page;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = lru_reference(page, last);
    pending_results.push_back(typed ? typed_res : r);
    references_sent++;
    if (!fast) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        pause_sender($urandom_range(1, 10));
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                 : $urandom_range(0, 12);
      end
    end
  endtask

  task automatic write_frame_count(input logic [CFG_W-1:0] value);
    pause_sender(0);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    frame_count_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: random stall patterns, with a long hold-off on request.
  int rx_mode = 0;
  int rx_mode_left = 0;
  int rx_hold_left = 0;
  int rx_cycle = 0;
  always @(negedge clk) begin
    rx_cycle++;
    if (hold_req) begin
      hold_req = 1'b0;
      rx_hold_left = 400;
    end
    if (rx_mode_left == 0) begin
      rx_mode      = $urandom_range(0, 3);
      rx_mode_left = $urandom_range(20, 200);
    end else begin
      rx_mode_left--;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_tready <= 1'b0;
    end else if (fast) begin
      m_tready <= 1'b1;
    end else begin
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= ((rx_cycle % 5) < 2);
      endcase
    end
  end

  function automatic void compare_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    lru_result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected, actual hit=%0d slot=%0d faults=%0d last=%0d",
                 $time, m_tuser, m_tdata[SLOT_OUT_W-1:0],
                 m_tdata[SLOT_OUT_W +: FAULT_W], m_tlast);
        mismatches++;
      end else begin
        exp_r = pending_results.pop_front();
        compare_field("hit", 32'(exp_r.hit), 32'(m_tuser));
        compare_field("frame_slot", 32'(exp_r.slot), 32'(m_tdata[SLOT_OUT_W-1:0]));
        compare_field("fault_total", 32'(exp_r.faults), 32'(m_tdata[SLOT_OUT_W +: FAULT_W]));
        compare_field("run_done", 32'(exp_r.done), 32'(m_tlast));
      end
    end
  end

  initial begin
    #40000000;
    $display("lru_page_replacement_unit regression: fail");
    $finish;
  end

  initial begin
    logic [PAGE_IN_W-1:0] pool [20];
    logic [PAGE_IN_W-1:0] page;
    int                   pool_size;
    int                   run_len;
    int                   random_start;
    int                   j;
    int                   k;
    bit                   end_run;
    lru_result_t          typed_res;

    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tlast   = 1'b0;
    m_tready  = 1'b0;
    clear_frames();
    frame_count_reg = FRAME_COUNT_RESET;

    directed_plan = '{
      // Fresh after reset: empty frames fill from index 0, page extremes.
      '{ROW_REF, 16'h0000, 1'b0, 1'b1, 1'b0, 4'd0, 16'd1},
      '{ROW_REF, 16'hFFFF, 1'b0, 1'b1, 1'b0, 4'd1, 16'd2},
      '{ROW_REF, 16'h0000, 1'b0, 1'b1, 1'b1, 4'd0, 16'd2},
      '{ROW_REF, 16'hFFFF, 1'b1, 1'b1, 1'b1, 4'd1, 16'd2},
      // The run end above clears the frames, stamps and fault total.
      '{ROW_REF, 16'h8001, 1'b0, 1'b1, 1'b0, 4'd0, 16'd1},
      '{ROW_REF, 16'h0002, 1'b0, 1'b0, 1'b0, 4'd0, 16'd0},
      '{ROW_REF, 16'h0004, 1'b0, 1'b0, 1'b0, 4'd0, 16'd0},
      '{ROW_REF, 16'h0008, 1'b0, 1'b0, 1'b0, 4'd0, 16'd0},
      // Shrink the frame count mid-run: frames 2 and 3 drop out of the search.
      '{ROW_CFG, 16'd2,    1'b0, 1'b0, 1'b0, 4'd0, 16'd0},
      '{ROW_REF, 16'h0004, 1'b0, 1'b0, 1'b0, 4'd0, 16'd0},
      '{ROW_REF, 16'h0002, 1'b0, 1'b0, 1'b0, 4'd0, 16'd0},
      '{ROW_REF, 16'h8001, 1'b0, 1'b0, 1'b0, 4'd0, 16'd0},
      // Grow again: the hidden frames kept their pages.
      '{ROW_CFG, 16'd16,   1'b0, 1'b0, 1'b0, 4'd0, 16'd0},
      '{ROW_REF, 16'h0008, 1'b0, 1'b0, 1'b0, 4'd0, 16'd0},
      '{ROW_REF, 16'h0004, 1'b1, 1'b0, 1'b0, 4'd0, 16'd0},
      // A frame count of zero acts as one frame.
      '{ROW_CFG, 16'd0,    1'b0, 1'b0, 1'b0, 4'd0, 16'd0},
      '{ROW_REF, 16'h1111, 1'b0, 1'b1, 1'b0, 4'd0, 16'd1},
      '{ROW_REF, 16'h2222, 1'b0, 1'b1, 1'b0, 4'd0, 16'd2},
      '{ROW_REF, 16'h2222, 1'b0, 1'b1, 1'b1, 4'd0, 16'd2},
      '{ROW_REF, 16'h1111, 1'b1, 1'b1, 1'b0, 4'd0, 16'd3},
      // Anything above sixteen frames is capped at sixteen.
      '{ROW_CFG, 16'd31,   1'b0, 1'b0, 1'b0, 4'd0, 16'd0},
      '{ROW_REF, 16'h7FFF, 1'b0, 1'b1, 1'b0, 4'd0, 16'd1},
      '{ROW_REF, 16'h7FFF, 1'b1, 1'b1, 1'b1, 4'd0, 16'd1},
      '{ROW_CFG, 16'd1,    1'b0, 1'b0, 1'b0, 4'd0, 16'd0},
      '{ROW_REF, 16'h0000, 1'b0, 1'b1, 1'b0, 4'd0, 16'd1},
      '{ROW_REF, 16'h0001, 1'b1, 1'b1, 1'b0, 4'd0, 16'd2},
      '{ROW_CFG, 16'd16,   1'b0, 1'b0, 1'b0, 4'd0, 16'd0}
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_CFG) begin
        write_frame_count(directed_plan[i].page[CFG_W-1:0]);
      end else begin
        typed_res.hit    = directed_plan[i].hit;
        typed_res.slot   = directed_plan[i].slot;
        typed_res.faults = directed_plan[i].faults;
        typed_res.done   = directed_plan[i].last;
        present_reference(directed_plan[i].page, directed_plan[i].last,
                          directed_plan[i].typed, typed_res);
      end
    end

    // The receiver holds off while references keep coming, so the unit backs up.
    hold_req = 1'b1;
    random_start = references_sent;
    while (references_sent - random_start < 1100) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 9))
          0: write_frame_count(5'd0);
          1: write_frame_count(5'd1);
          2: write_frame_count(5'd16);
          3: write_frame_count(5'd17);
          4: write_frame_count(5'd31);
          default: write_frame_count(CFG_W'($urandom_range(1, 16)));
        endcase
      end
      pool_size = $urandom_range(1, 20);
      for (j = 0; j < pool_size; j++) pool[j] = PAGE_IN_W'($urandom);
      run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 30);
      // Most runs end with a marked reference; the rest carry over to the next setting.
      end_run = ($urandom_range(0, 4) != 0);
      for (j = 0; j < run_len; j++) begin
        page = ($urandom_range(0, 9) == 0) ? PAGE_IN_W'($urandom)
                                           : pool[$urandom_range(0, pool_size - 1)];
        present_reference(page, (end_run && j == run_len - 1) || ($urandom_range(0, 99) == 0),
                          1'b0, typed_res);
      end
    end

    // A short stretch with no sender gaps and an always-ready receiver: alternating
    // pages on a single frame, so every reference faults.
    write_frame_count(5'd1);
    fast = 1'b1;
    for (k = 0; k < 32; k++) begin
      present_reference(k[0] ? 16'h00FF : 16'hFF00, k == 31, 1'b0, typed_res);
    end
    fast = 1'b0;

    pause_sender(0);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("lru_page_replacement_unit regression: pass");
    end else begin
      $display("lru_page_replacement_unit regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/lrupr_pkg.sv
rtl/core/lrupr_frame_mem.sv
rtl/core/lrupr_scan_unit.sv
rtl/core/lru_page_replacement_unit.sv
tb/tb_lru_page_replacement_unit.sv
